[rtl/pptr_pkg.sv]
// Shared types and constants for the parallel port and timer block.
`timescale 1ns / 1ps
`default_nettype none

package pptr_pkg;

    localparam int ADDR_W   = 24;
    localparam int OFF_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 16;
    localparam int SIZE_W   = 3;
    localparam int CNT_W    = 24;
    localparam int NUM_REGS = 18;
    localparam int SLOT_W   = 5;

    localparam int DEF_PRESCALE_BITS = 10;
    localparam int DEF_RELOAD_VALUE  = 24'hFFFFFF;
    localparam int DEF_REGISTER_SPAN = 54;

    localparam logic [ADDR_W-1:0] BASE_RESET = 24'h800000;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd2;

    // Operation handed from the input stage to the register file
    typedef struct packed {
        logic              valid;
        logic [1:0]        cmd;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] access_size;
        logic [DATA_W-1:0] write_data;
    } pptr_op_t;

    // Control from the register file to the timer
    typedef struct packed {
        logic tick;
        logic clear_flag;
    } tmr_ctrl_t;

endpackage

`default_nettype wire

[rtl/pptr_req_if.sv]
// Request channel interface: valid/ready handshake with the bus access payload.
`timescale 1ns / 1ps
`default_nettype none

interface pptr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] bus_address;
    logic [2:0]  access_size;
    logic [15:0] write_data;

    modport source (output valid, output cmd, output bus_address, output access_size,
                    output write_data, input ready);
    modport sink   (input valid, input cmd, input bus_address, input access_size,
                    input write_data, output ready);
endinterface

`default_nettype wire

[rtl/pptr_rsp_if.sv]
// Response channel interface: valid/ready handshake with the read data payload.
`timescale 1ns / 1ps
`default_nettype none

interface pptr_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

[rtl/pptr_timer.sv]
// Tick prescaler, hidden down counter and underflow flag.
`timescale 1ns / 1ps
`default_nettype none

module pptr_timer
    import pptr_pkg::*;
#(
    parameter int PRESCALE_BITS = DEF_PRESCALE_BITS,
    parameter int RELOAD_VALUE  = DEF_RELOAD_VALUE
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tmr_ctrl_t ctrl,
    output logic           underflow
);

    logic [PRESCALE_BITS-1:0] presc_reg, presc_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     flag_reg, flag_next;

    always_comb
    begin
        presc_next = presc_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (ctrl.tick)
        begin
            presc_next = presc_reg + 1'b1;
            // prescaler wraps to zero: step the counter
            if (&presc_reg)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    count_next = CNT_W'(RELOAD_VALUE);
                    flag_next  = 1'b1;
                end
            end
        end
        if (ctrl.clear_flag)
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_reg <= '0;
            count_reg <= CNT_W'(RELOAD_VALUE);
            flag_reg  <= 1'b0;
        end
        else
        begin
            presc_reg <= presc_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign underflow = flag_reg;

endmodule

`default_nettype wire

[rtl/pptr_regfile.sv]
// Byte register file with read and write decode of the register window.
`timescale 1ns / 1ps
`default_nettype none

module pptr_regfile
    import pptr_pkg::*;
#(
    parameter int REGISTER_SPAN = DEF_REGISTER_SPAN
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pptr_op_t          op,
    input  wire logic              underflow,
    output logic [DATA_W-1:0]      read_data,
    output tmr_ctrl_t              tmr_ctrl
);

    localparam logic [OFF_W-1:0] OFF_PORT_LAST = 6'h19;
    localparam logic [OFF_W-1:0] OFF_PSR       = 6'h1B;
    localparam logic [OFF_W-1:0] OFF_TCR       = 6'h21;
    localparam logic [OFF_W-1:0] OFF_TIVR      = 6'h23;
    localparam logic [OFF_W-1:0] OFF_CNTH_RD   = 6'h27;
    localparam logic [OFF_W-1:0] OFF_CNTM_RD   = 6'h29;
    localparam logic [OFF_W-1:0] OFF_CNTL_RD   = 6'h2B;
    localparam logic [OFF_W-1:0] OFF_TSR       = 6'h2D;
    localparam logic [OFF_W-1:0] OFF_CNTH_WR   = 6'h2B;
    localparam logic [OFF_W-1:0] OFF_CNTM_WR   = 6'h2D;
    localparam logic [OFF_W-1:0] OFF_CNTL_WR   = 6'h2F;
    localparam logic [OFF_W-1:0] OFF_TSR_CLR   = 6'h31;

    localparam logic [SLOT_W-1:0] SLOT_A_DIR    = 5'd2;
    localparam logic [SLOT_W-1:0] SLOT_B_DIR    = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_C_DIR    = 5'd4;
    localparam logic [SLOT_W-1:0] SLOT_PORT_VEC = 5'd5;
    localparam logic [SLOT_W-1:0] SLOT_A_DATA   = 5'd8;
    localparam logic [SLOT_W-1:0] SLOT_B_DATA   = 5'd9;
    localparam logic [SLOT_W-1:0] SLOT_C_DATA   = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_TCR      = 5'd13;
    localparam logic [SLOT_W-1:0] SLOT_TIVR     = 5'd14;
    localparam logic [SLOT_W-1:0] SLOT_CNTH     = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_CNTM     = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_CNTL     = 5'd17;

    localparam logic [BYTE_W-1:0] VEC_MASK   = 8'hFC;
    localparam logic [BYTE_W-1:0] UNMAPPED   = 8'hFF;

    logic [BYTE_W-1:0] regs_reg [NUM_REGS];

    logic [OFF_W-1:0]  off2;
    logic              second;
    logic [OFF_W-1:0]  odd_off;
    logic [BYTE_W-1:0] odd_byte;
    logic              is_byte;
    logic              is_word;

    logic              wr_hit;
    logic [BYTE_W-1:0] wr_byte;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [BYTE_W-1:0] wr_val;
    logic              wr_clr;

    // Only odd offsets map to anything, and of the two bytes of a word access
    // exactly one sits at an odd offset; the even one reads as unmapped (zero when
    // past the span) and ignores writes. Decode the odd one only.
    assign off2    = op.offset + 1'b1;
    assign second  = ({1'b0, op.offset} + 7'd1) < 7'(REGISTER_SPAN);
    assign odd_off = op.offset[0] ? op.offset : off2;
    assign is_byte = (op.access_size == SIZE_BYTE);
    assign is_word = (op.access_size == SIZE_WORD);

    always_comb
    begin
        case (odd_off)
            OFF_PSR:     odd_byte = '0;
            OFF_TSR:     odd_byte = {{(BYTE_W-1){1'b0}}, underflow};
            OFF_TCR:     odd_byte = regs_reg[SLOT_TCR];
            OFF_TIVR:    odd_byte = regs_reg[SLOT_TIVR];
            OFF_CNTH_RD: odd_byte = regs_reg[SLOT_CNTH];
            OFF_CNTM_RD: odd_byte = regs_reg[SLOT_CNTM];
            OFF_CNTL_RD: odd_byte = regs_reg[SLOT_CNTL];
            default:
            begin
                if (odd_off <= OFF_PORT_LAST)
                begin
                    odd_byte = regs_reg[odd_off[OFF_W-1:1]];
                end
                else
                begin
                    odd_byte = UNMAPPED;
                end
            end
        endcase
    end

    always_comb
    begin
        read_data = '0;
        if (op.cmd == CMD_READ)
        begin
            if (is_byte)
            begin
                read_data = {8'h00, op.offset[0] ? odd_byte : UNMAPPED};
            end
            else if (is_word)
            begin
                read_data[15:8] = op.offset[0] ? odd_byte : UNMAPPED;
                if (second)
                begin
                    read_data[7:0] = op.offset[0] ? UNMAPPED : odd_byte;
                end
            end
        end
    end

    // Write decode: a byte access hits only at an odd offset; a word access
    // hits through its high byte at an odd offset or its low byte otherwise.
    always_comb
    begin
        wr_hit  = 1'b0;
        wr_byte = op.write_data[7:0];
        if (op.valid && op.cmd == CMD_WRITE)
        begin
            if (is_byte)
            begin
                wr_hit = op.offset[0];
            end
            else if (is_word)
            begin
                wr_hit  = op.offset[0] || second;
                wr_byte = op.offset[0] ? op.write_data[15:8] : op.write_data[7:0];
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_slot = odd_off[OFF_W-1:1];
        wr_val  = wr_byte;
        wr_clr  = 1'b0;
        case (odd_off)
            OFF_TCR:     begin wr_en = wr_hit; wr_slot = SLOT_TCR;  end
            OFF_TIVR:    begin wr_en = wr_hit; wr_slot = SLOT_TIVR; end
            OFF_CNTH_WR: begin wr_en = wr_hit; wr_slot = SLOT_CNTH; end
            OFF_CNTM_WR: begin wr_en = wr_hit; wr_slot = SLOT_CNTM; end
            OFF_CNTL_WR: begin wr_en = wr_hit; wr_slot = SLOT_CNTL; end
            OFF_TSR_CLR: wr_clr = wr_hit;
            default:
            begin
                if (odd_off <= OFF_PORT_LAST)
                begin
                    wr_en = wr_hit;
                    case (wr_slot)
                        SLOT_PORT_VEC: wr_val = wr_byte & VEC_MASK;
                        SLOT_A_DATA:   wr_val = wr_byte & regs_reg[SLOT_A_DIR];
                        SLOT_B_DATA:   wr_val = wr_byte & regs_reg[SLOT_B_DIR];
                        SLOT_C_DATA:   wr_val = wr_byte & regs_reg[SLOT_C_DIR];
                        default:       wr_val = wr_byte;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            regs_reg[wr_slot] <= wr_val;
        end
    end

    assign tmr_ctrl.tick       = op.valid && (op.cmd == CMD_TICK);
    assign tmr_ctrl.clear_flag = wr_clr;

endmodule

`default_nettype wire

[rtl/parallel_port_timer_registers.sv]
// Top level of the parallel port and timer register block.
//
// Usage:
//   request carries one bus item per transfer: cmd (read, write, tick),
//   bus_address, access_size (1 byte, 2 word) and write_data. response
//   returns one read_data per request, in order; writes and ticks return 0.
//   cfg_wr_en/cfg_wr_data load base_address, the start of the 64-byte window;
//   write it only while no request is in flight.
// Pipeline and throughput:
//   A request transfers into the input register, is decoded and applied to
//   the register file and timer as it advances, and its result is captured
//   in the output register, from which it transfers out on response. One
//   request per cycle is sustained while response is taken; the register file
//   update is a single pass of decode logic.
// Reset:
//   rst_n clears the byte registers, the underflow flag and the prescaler,
//   loads the down counter with the reload value and base_address with
//   0x800000. Both pipeline stages come up empty.
// Stall:
//   When response is not taken the result holds in the output register, the
//   next request waits in the input register, and request.ready drops only
//   once both are full.
`timescale 1ns / 1ps
`default_nettype none

module parallel_port_timer_registers
    import pptr_pkg::*;
#(
    parameter int PRESCALE_BITS = DEF_PRESCALE_BITS,
    parameter int RELOAD_VALUE  = DEF_RELOAD_VALUE,
    parameter int REGISTER_SPAN = DEF_REGISTER_SPAN
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_wr_data,
    pptr_req_if.sink               request,
    pptr_rsp_if.source             response
);

    // Configuration
    logic [ADDR_W-1:0] base_reg;

    // Input stage
    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_cmd_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic [DATA_W-1:0] s1_data_reg;

    // Output stage
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;

    logic              in_xfer;
    logic              advance;
    pptr_op_t          op;
    logic [DATA_W-1:0] rd_data;
    tmr_ctrl_t         tmr_ctrl;
    logic              underflow;

    // Advance the input stage whenever the output register is free or drains
    // in the same cycle; accept a new request whenever the input stage will
    // be empty.
    assign advance       = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || advance;
    assign in_xfer       = request.valid && request.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold unless a transfer or an advance moves them
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg  <= request.cmd;
            s1_addr_reg <= request.bus_address;
            s1_size_reg <= request.access_size;
            s1_data_reg <= request.write_data;
        end
        if (advance)
        begin
            out_data_reg <= rd_data;
        end
    end

    // Offset inside the window: only the low six bits of the difference count
    assign op.valid       = advance;
    assign op.cmd         = s1_cmd_reg;
    assign op.offset      = s1_addr_reg[OFF_W-1:0] - base_reg[OFF_W-1:0];
    assign op.access_size = s1_size_reg;
    assign op.write_data  = s1_data_reg;

    pptr_regfile #(
        .REGISTER_SPAN (REGISTER_SPAN)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .underflow (underflow),
        .read_data (rd_data),
        .tmr_ctrl  (tmr_ctrl)
    );

    pptr_timer #(
        .PRESCALE_BITS (PRESCALE_BITS),
        .RELOAD_VALUE  (RELOAD_VALUE)
    ) u_timer (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tmr_ctrl),
        .underflow (underflow)
    );

    assign response.valid     = out_valid_reg;
    assign response.read_data = out_data_reg;

`ifndef SYNTH
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> response.valid)
        else $error("advanced item did not reach the output register");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> request.ready)
        else $error("request stalled with an empty input stage");

    a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_cmd_reg != CMD_READ) |=> (response.read_data == '0))
        else $error("write or tick returned nonzero read data");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !response.ready) |=> s1_valid_reg)
        else $error("input stage dropped an item during a stall");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the parallel port and timer register block.
`timescale 1ns / 1ps

module tb;
    import pptr_pkg::*;

    // Command code outside the defined set; the block must ignore it
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Access sizes other than byte and word
    localparam logic [SIZE_W-1:0] SIZE_EMPTY = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_ODD   = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 3'd7;

    // Register offsets inside the window
    localparam logic [OFF_W-1:0] OFS_A_DIR    = 6'h05;
    localparam logic [OFF_W-1:0] OFS_B_DIR    = 6'h07;
    localparam logic [OFF_W-1:0] OFS_C_DIR    = 6'h09;
    localparam logic [OFF_W-1:0] OFS_VECTOR   = 6'h0B;
    localparam logic [OFF_W-1:0] OFS_A_DATA   = 6'h11;
    localparam logic [OFF_W-1:0] OFS_B_DATA   = 6'h13;
    localparam logic [OFF_W-1:0] OFS_C_DATA   = 6'h19;
    localparam logic [OFF_W-1:0] OFS_STATUS   = 6'h1B;
    localparam logic [OFF_W-1:0] OFS_TMR_CTRL = 6'h21;
    localparam logic [OFF_W-1:0] OFS_TMR_VEC  = 6'h23;
    localparam logic [OFF_W-1:0] OFS_PRELOAD  = 6'h25;
    localparam logic [OFF_W-1:0] OFS_CNT_H_RD = 6'h27;
    localparam logic [OFF_W-1:0] OFS_CNT_M_RD = 6'h29;
    localparam logic [OFF_W-1:0] OFS_CNT_L_RD = 6'h2B;
    localparam logic [OFF_W-1:0] OFS_FLAG_RD  = 6'h2D;
    localparam logic [OFF_W-1:0] OFS_CNT_H_WR = 6'h2B;
    localparam logic [OFF_W-1:0] OFS_CNT_M_WR = 6'h2D;
    localparam logic [OFF_W-1:0] OFS_CNT_L_WR = 6'h2F;
    localparam logic [OFF_W-1:0] OFS_FLAG_CLR = 6'h31;
    localparam logic [OFF_W-1:0] OFS_LAST     = 6'h3F;

    localparam logic [BYTE_W-1:0] VECTOR_MASK   = 8'hFC;
    localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_BYTE   = 8'h00;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] bus_address;
        logic [SIZE_W-1:0] access_size;
        logic [DATA_W-1:0] write_data;
    } bus_item_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [ADDR_W-1:0] cfg_wr_data;

    pptr_req_if request_bus();
    pptr_rsp_if response_bus();

    parallel_port_timer_registers DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request_bus),
        .response    (response_bus)
    );

    // Shadow copy of the register file, kept by write offset. Count bytes are
    // read back at offsets four below where they are written.
    logic [BYTE_W-1:0] reg_bytes [64];
    logic              underflow;
    logic [CNT_W-1:0]  down_count;
    logic [DEF_PRESCALE_BITS-1:0] prescale;
    logic [ADDR_W-1:0] window_base;

    // Read data owed by the block, oldest first
    logic [DATA_W-1:0] expected_read_data [$];

    int error_count;
    int items_sent;
    int results_checked;
    int bases_loaded;
    int send_idle_pct;
    int rsp_stall_pct;

    // ------------------------------------------------------------------
    // Register file predictor
    // ------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] peek_byte(input logic [OFF_W-1:0] off);
        case (off)
            OFS_STATUS:               return STATUS_BYTE;
            OFS_FLAG_RD:              return {7'd0, underflow};
            OFS_TMR_CTRL, OFS_TMR_VEC: return reg_bytes[off];
            OFS_CNT_H_RD:             return reg_bytes[OFS_CNT_H_WR];
            OFS_CNT_M_RD:             return reg_bytes[OFS_CNT_M_WR];
            OFS_CNT_L_RD:             return reg_bytes[OFS_CNT_L_WR];
            default:
            begin
                // Port block: odd offsets up to C data
                if (off[0] && off <= OFS_C_DATA)
                    return reg_bytes[off];
                return UNMAPPED_BYTE;
            end
        endcase
    endfunction

    function automatic void poke_byte(input logic [OFF_W-1:0] off,
                                      input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] v;
        v = d;
        if (off[0] && off <= OFS_C_DATA)
        begin
            // Port data only keeps bits whose direction bit is set; the vector drops its low two bits
            case (off)
                OFS_VECTOR: v = v & VECTOR_MASK;
                OFS_A_DATA: v = v & reg_bytes[OFS_A_DIR];
                OFS_B_DATA: v = v & reg_bytes[OFS_B_DIR];
                OFS_C_DATA: v = v & reg_bytes[OFS_C_DIR];
                default: ;
            endcase
            reg_bytes[off] = v;
        end
        else
        begin
            case (off)
                OFS_TMR_CTRL, OFS_TMR_VEC, OFS_CNT_H_WR, OFS_CNT_M_WR, OFS_CNT_L_WR:
                    reg_bytes[off] = v;
                OFS_FLAG_CLR: underflow = 1'b0;
                default: ;
            endcase
        end
    endfunction

    function automatic void advance_timer();
        prescale = prescale + 1'b1;
        if (prescale == '0)
        begin
            if (down_count != '0)
                down_count = down_count - 1'b1;
            else
            begin
                down_count = CNT_W'(DEF_RELOAD_VALUE);
                underflow  = 1'b1;
            end
        end
    endfunction

    // Apply one bus item to the shadow state and return the read data it yields
    function automatic logic [DATA_W-1:0] apply_bus_item(input bus_item_t it);
        logic [ADDR_W-1:0] rel;
        logic [OFF_W-1:0]  off;
        logic [OFF_W-1:0]  off2;
        logic              has_second;
        logic [DATA_W-1:0] rd;
        rel        = it.bus_address - window_base;
        off        = rel[OFF_W-1:0];
        off2       = off + 1'b1;
        has_second = (int'(off) + 1) < DEF_REGISTER_SPAN;
        rd         = '0;
        case (it.cmd)
            CMD_READ:
            begin
                if (it.access_size == SIZE_BYTE)
                    rd[7:0] = peek_byte(off);
                else if (it.access_size == SIZE_WORD)
                begin
                    rd[15:8] = peek_byte(off);
                    if (has_second)
                        rd[7:0] = peek_byte(off2);
                end
            end
            CMD_WRITE:
            begin
                if (it.access_size == SIZE_BYTE)
                    poke_byte(off, it.write_data[7:0]);
                else if (it.access_size == SIZE_WORD)
                begin
                    poke_byte(off, it.write_data[15:8]);
                    if (has_second)
                        poke_byte(off2, it.write_data[7:0]);
                end
            end
            CMD_TICK: advance_timer();
            default: ;
        endcase
        return rd;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic bus_item_t random_bus_item();
        bus_item_t               it;
        int                      pick;
        logic [OFF_W-1:0]        off;
        logic [ADDR_W-OFF_W-1:0] hi_bits;
        pick = $urandom_range(99);
        if (pick < 40)
            it.cmd = CMD_READ;
        else if (pick < 78)
            it.cmd = CMD_WRITE;
        else if (pick < 95)
            it.cmd = CMD_TICK;
        else
            it.cmd = CMD_UNKNOWN;

        pick = $urandom_range(9);
        if (pick < 5)
            it.access_size = SIZE_BYTE;
        else if (pick < 9)
            it.access_size = SIZE_WORD;
        else
            it.access_size = SIZE_W'($urandom_range(7));

        // Favor the odd offsets where the registers live
        if ($urandom_range(1) != 0)
            off = OFF_W'(2 * $urandom_range(24) + 1);
        else
            off = OFF_W'($urandom_range(63));

        // Mostly stay on the base window, sometimes hit an alias or anywhere
        pick = $urandom_range(9);
        hi_bits = (pick < 3) ? (ADDR_W-OFF_W)'($urandom) : '0;
        if (pick == 9)
            it.bus_address = ADDR_W'($urandom);
        else
            it.bus_address = window_base + {hi_bits, off};

        pick = $urandom_range(9);
        if (pick == 0)
            it.write_data = '1;
        else if (pick == 1)
            it.write_data = '0;
        else
            it.write_data = DATA_W'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request driver and result checker
    // ------------------------------------------------------------------

    // Drive one item, hold it until the transfer, then record its read data.
    // Valid stays high on return so back-to-back items need no extra step.
    task automatic send_item(input bus_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid       <= 1'b1;
        request_bus.cmd         <= it.cmd;
        request_bus.bus_address <= it.bus_address;
        request_bus.access_size <= it.access_size;
        request_bus.write_data  <= it.write_data;
        do
            @(posedge clk);
        while (!request_bus.ready);
        expected_read_data.push_back(apply_bus_item(it));
        items_sent++;
    endtask

    // Send an item addressed relative to the current window base
    task automatic send_at(input logic [1:0] cmd, input logic [OFF_W-1:0] off,
                           input logic [SIZE_W-1:0] size, input logic [DATA_W-1:0] data);
        send_item('{cmd, window_base + ADDR_W'(off), size, data});
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_item(random_bus_item());
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic wait_until_drained();
        request_bus.valid <= 1'b0;
        while (expected_read_data.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_base(input logic [ADDR_W-1:0] value);
        wait_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_base = value;
        bases_loaded++;
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Sample the response at each edge, compare with the oldest owed value,
    // and pick the next ready level from the current stall rate.
    initial
    begin : check_results
        logic [DATA_W-1:0] want;
        response_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (response_bus.valid && response_bus.ready)
            begin
                if (expected_read_data.size() == 0)
                    report_mismatch($sformatf("response with nothing owed, read_data %h",
                                              response_bus.read_data));
                else
                begin
                    want = expected_read_data.pop_front();
                    results_checked++;
                    if (response_bus.read_data !== want)
                        report_mismatch($sformatf("result %0d: read_data %h, predicted %h",
                                                  results_checked, response_bus.read_data,
                                                  want));
                end
            end
            response_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the register map at the reset base: masking, split count offsets,
    // preload and status, flag clear, word past span and wrap, odd sizes,
    // unknown command, aliases at the far ends of the address space.
    task automatic test_register_map();
        send_at(CMD_WRITE,   OFS_A_DIR,        SIZE_BYTE,  16'h00A5);
        send_at(CMD_WRITE,   OFS_A_DATA,       SIZE_BYTE,  16'hFFFF);
        send_at(CMD_READ,    OFS_A_DATA - 1'b1, SIZE_WORD, 16'h0000);
        send_at(CMD_WRITE,   OFS_VECTOR,       SIZE_BYTE,  16'h00FF);
        send_at(CMD_READ,    OFS_VECTOR,       SIZE_BYTE,  16'h0000);
        send_at(CMD_WRITE,   OFS_CNT_H_WR - 1'b1, SIZE_WORD, 16'h1234);
        send_at(CMD_READ,    OFS_CNT_H_RD,     SIZE_WORD,  16'h0000);
        send_at(CMD_WRITE,   OFS_PRELOAD,      SIZE_BYTE,  16'h0055);
        send_at(CMD_READ,    OFS_STATUS,       SIZE_BYTE,  16'h0000);
        send_at(CMD_WRITE,   OFS_STATUS,       SIZE_BYTE,  16'hFFFF);
        send_at(CMD_READ,    OFS_FLAG_RD,      SIZE_BYTE,  16'h0000);
        send_at(CMD_WRITE,   OFS_FLAG_CLR,     SIZE_BYTE,  16'hFFFF);
        send_at(CMD_READ,    6'h35,            SIZE_WORD,  16'h0000);
        send_at(CMD_WRITE,   OFS_LAST,         SIZE_WORD,  16'hFFFF);
        send_at(CMD_READ,    OFS_LAST,         SIZE_WORD,  16'h0000);
        send_at(CMD_READ,    OFS_A_DATA,       SIZE_EMPTY, 16'h0000);
        send_at(CMD_WRITE,   OFS_A_DIR,        SIZE_ODD,   16'hFFFF);
        send_at(CMD_READ,    OFS_A_DIR,        SIZE_MAX,   16'hFFFF);
        send_at(CMD_WRITE,   OFS_A_DIR - 1'b1, SIZE_WORD,  16'hFFFF);
        send_at(CMD_WRITE,   OFS_A_DATA,       SIZE_BYTE,  16'h0000);
        send_at(CMD_READ,    OFS_A_DATA,       SIZE_BYTE,  16'h0000);
        send_item('{CMD_UNKNOWN, 24'hFFFFFF, SIZE_WORD, 16'hFFFF});
        send_at(CMD_TICK,    OFS_A_DATA,       SIZE_BYTE,  16'h0000);
        send_item('{CMD_READ, 24'hFFFFFF, SIZE_BYTE, 16'h0000});
        send_item('{CMD_READ, 24'h000000, SIZE_WORD, 16'h0000});
    endtask

    // Move the window: zero, all ones (offset math wraps), random, back to reset
    task automatic test_window_base();
        load_base('0);
        send_random(60);
        load_base('1);
        send_random(60);
        load_base(ADDR_W'($urandom));
        send_random(60);
        load_base(ADDR_W'($urandom));
        send_random(60);
        load_base(BASE_RESET);
        send_random(60);
    endtask

    // Random traffic under each pattern of sender gaps and receiver stalls
    task automatic test_idle_patterns();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_random(300);
        send_idle_pct = 84;
        rsp_stall_pct = 0;
        send_random(300);
        send_idle_pct = 0;
        rsp_stall_pct = 84;
        send_random(300);
        send_idle_pct = 35;
        rsp_stall_pct = 35;
        send_random(300);
        send_idle_pct = 0;
        rsp_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, sequencing, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= '0;
        request_bus.valid       <= 1'b0;
        request_bus.cmd         <= CMD_READ;
        request_bus.bus_address <= '0;
        request_bus.access_size <= SIZE_BYTE;
        request_bus.write_data  <= '0;

        // Predictor starts from the reset state of the block
        foreach (reg_bytes[i])
            reg_bytes[i] = '0;
        underflow     = 1'b0;
        down_count    = CNT_W'(DEF_RELOAD_VALUE);
        prescale      = '0;
        window_base   = BASE_RESET;
        error_count   = 0;
        items_sent    = 0;
        results_checked = 0;
        bases_loaded  = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_map();
        test_window_base();
        test_idle_patterns();

        wait_until_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d transfers and %0d checked results over %0d window bases,",
                 items_sent, results_checked, bases_loaded + 1);
        $display("with sender gaps and receiver stalls at 0, 35 and 84 percent.");
        if (error_count == 0 && expected_read_data.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still owed", expected_read_data.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[parallel_port_timer_registers.f]
rtl/pptr_pkg.sv
rtl/pptr_req_if.sv
rtl/pptr_rsp_if.sv
rtl/pptr_timer.sv
rtl/pptr_regfile.sv
rtl/parallel_port_timer_registers.sv
sim/tb.sv
